// ===== rtl/nmea_rmc_position_parser_macros.svh =====
// ----------------------------------------------------------------------------
// NMEA RMC parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_PARSER_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_MACROS_SVH

// same-cycle implication
`define NMEA_RMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NMEA_RMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nmea_rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_pkg
// Types, character codes and field indexes of the RMC position parser.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

    localparam int COORD_FIELD_CHARS_DEF = 19;
    localparam int SHORT_FIELD_CHARS_DEF = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_C_LC   = 8'h63;
    localparam logic [7:0] CH_M_LC   = 8'h6D;
    localparam logic [7:0] CH_R_LC   = 8'h72;

    typedef logic [2:0] hdr_pos_t;
    localparam hdr_pos_t HDR_POS_R    = 3'd2;
    localparam hdr_pos_t HDR_POS_M    = 3'd3;
    localparam hdr_pos_t HDR_POS_C    = 3'd4;

    typedef logic [2:0] field_idx_t;
    localparam field_idx_t FIELD_FIRST    = 3'd0;
    localparam field_idx_t FIELD_STATUS   = 3'd2;
    localparam field_idx_t FIELD_LAT      = 3'd3;
    localparam field_idx_t FIELD_LAT_HEMI = 3'd4;
    localparam field_idx_t FIELD_LON      = 3'd5;
    localparam field_idx_t FIELD_LON_HEMI = 3'd6;
    localparam field_idx_t FIELD_PAST     = 3'd7;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HEADER,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        HEMI_N,
        HEMI_S,
        HEMI_E,
        HEMI_W
    } hemi_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_sentence;
    } sentence_word_t;

    typedef struct packed {
        logic        fix_valid;
        logic [31:0] lat_raw;
        logic [1:0]  lat_hemi;
        logic [31:0] lon_raw;
        logic [1:0]  lon_hemi;
    } fix_word_t;

endpackage

// ===== rtl/nmea_rmc_stream_if.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface nmea_rmc_stream_if #(
    parameter type payload_t = logic [7:0]
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== rtl/nmea_rmc_position_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser
// The fix word is loaded into the result register when the final byte leaves the byte register.
// Throughput: one byte per cycle unless stalled; byte register, then parse and result register.
// A pending result stalls input only when the next final byte reaches the parser.
// Reset: asynchronous, active low; parser returns to blank skipping, no result.
// ----------------------------------------------------------------------------
`include "nmea_rmc_position_parser_macros.svh"

module nmea_rmc_position_parser #(
    parameter int COORD_FIELD_CHARS = nmea_rmc_pkg::COORD_FIELD_CHARS_DEF,
    parameter int SHORT_FIELD_CHARS = nmea_rmc_pkg::SHORT_FIELD_CHARS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    nmea_rmc_stream_if.sink           sentence,
    nmea_rmc_stream_if.source         fix
);

    localparam int MAX_CHARS = (COORD_FIELD_CHARS > SHORT_FIELD_CHARS) ?
                               COORD_FIELD_CHARS : SHORT_FIELD_CHARS;
    localparam int LEN_W     = $clog2(MAX_CHARS + 1);
    localparam logic [LEN_W-1:0] COORD_LIM = LEN_W'(COORD_FIELD_CHARS);
    localparam logic [LEN_W-1:0] SHORT_LIM = LEN_W'(SHORT_FIELD_CHARS);

    // input byte register
    logic                         s1_valid_reg;
    nmea_rmc_pkg::sentence_word_t s1_word_reg;
    logic                         s1_fire;
    logic [7:0]                   c;

    // parser state
    nmea_rmc_pkg::phase_t      phase_reg,   phase_next;
    nmea_rmc_pkg::hdr_pos_t    hdr_pos_reg, hdr_pos_next;
    logic                      hdr_ok_reg,  hdr_ok_next;
    nmea_rmc_pkg::field_idx_t  idx_reg,     idx_next;
    logic [LEN_W-1:0]          len_reg,     len_next;
    logic                      stopped_reg, stopped_next;
    logic                      ended_reg,   ended_next;
    logic                      err_reg,     err_next;
    logic [31:0]               lat_reg,     lat_next;
    logic [31:0]               lon_reg,     lon_next;
    nmea_rmc_pkg::hemi_t       lat_dir_reg, lat_dir_next;
    nmea_rmc_pkg::hemi_t       lon_dir_reg, lon_dir_next;

    // result register
    logic                      out_valid_reg;
    nmea_rmc_pkg::fix_word_t   out_word_reg;
    logic                      out_load;
    logic                      fix_ok;

    // byte classes
    logic                      hdr_step;
    logic                      in_data_field;
    logic [LEN_W-1:0]          field_limit;
    logic                      is_digit;
    logic                      hemi_hit;
    nmea_rmc_pkg::hemi_t       hemi_val;
    logic [31:0]               digit_val;

    assign c         = s1_word_reg.char_byte;
    assign s1_fire   = s1_valid_reg &&
                       (!s1_word_reg.end_of_sentence || !out_valid_reg || fix.ready);
    assign out_load  = s1_fire && s1_word_reg.end_of_sentence;

    assign sentence.ready = !s1_valid_reg || s1_fire;
    assign fix.valid      = out_valid_reg;
    assign fix.payload    = out_word_reg;

    assign in_data_field = (idx_reg >= nmea_rmc_pkg::FIELD_STATUS) &&
                           (idx_reg <= nmea_rmc_pkg::FIELD_LON_HEMI);
    assign field_limit   = ((idx_reg == nmea_rmc_pkg::FIELD_LAT) ||
                            (idx_reg == nmea_rmc_pkg::FIELD_LON)) ? COORD_LIM : SHORT_LIM;
    assign is_digit      = (c >= nmea_rmc_pkg::CH_ZERO) && (c <= nmea_rmc_pkg::CH_NINE);
    assign digit_val     = {28'd0, c[3:0]};

    always_comb
    begin
        hemi_hit = 1'b1;
        hemi_val = nmea_rmc_pkg::HEMI_N;
        case (c)
            nmea_rmc_pkg::CH_N: hemi_val = nmea_rmc_pkg::HEMI_N;
            nmea_rmc_pkg::CH_S: hemi_val = nmea_rmc_pkg::HEMI_S;
            nmea_rmc_pkg::CH_E: hemi_val = nmea_rmc_pkg::HEMI_E;
            nmea_rmc_pkg::CH_W: hemi_val = nmea_rmc_pkg::HEMI_W;
            default:            hemi_hit = 1'b0;
        endcase
    end

    // next state of the parser for the byte in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_pos_next = hdr_pos_reg;
        hdr_ok_next  = hdr_ok_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        stopped_next = stopped_reg;
        ended_next   = ended_reg;
        err_next     = err_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        lat_dir_next = lat_dir_reg;
        lon_dir_next = lon_dir_reg;
        hdr_step     = 1'b0;

        if (!ended_reg)
        begin
            if (phase_reg == nmea_rmc_pkg::PH_SKIP)
            begin
                if (!(c inside {nmea_rmc_pkg::CH_SPACE, nmea_rmc_pkg::CH_TAB}))
                begin
                    phase_next = nmea_rmc_pkg::PH_HEADER;
                    hdr_step   = (c != nmea_rmc_pkg::CH_DOLLAR);
                end
            end
            else if (phase_reg == nmea_rmc_pkg::PH_HEADER)
            begin
                hdr_step = 1'b1;
            end

            if (hdr_step)
            begin
                if (c == nmea_rmc_pkg::CH_NUL)
                begin
                    hdr_ok_next = 1'b0;
                end
                else
                begin
                    case (hdr_pos_reg)
                        nmea_rmc_pkg::HDR_POS_R:
                            if (!(c inside {nmea_rmc_pkg::CH_R, nmea_rmc_pkg::CH_R_LC}))
                                hdr_ok_next = 1'b0;
                        nmea_rmc_pkg::HDR_POS_M:
                            if (!(c inside {nmea_rmc_pkg::CH_M, nmea_rmc_pkg::CH_M_LC}))
                                hdr_ok_next = 1'b0;
                        nmea_rmc_pkg::HDR_POS_C:
                            if (!(c inside {nmea_rmc_pkg::CH_C, nmea_rmc_pkg::CH_C_LC}))
                                hdr_ok_next = 1'b0;
                        default: ;
                    endcase
                    hdr_pos_next = hdr_pos_reg + 3'd1;
                    if (hdr_pos_reg == nmea_rmc_pkg::HDR_POS_C)
                        phase_next = nmea_rmc_pkg::PH_DONE;
                end
            end

            if (c == nmea_rmc_pkg::CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else if (!stopped_reg)
            begin
                if (c inside {nmea_rmc_pkg::CH_CR, nmea_rmc_pkg::CH_LF})
                begin
                    stopped_next = 1'b1;
                end
                else if (c inside {nmea_rmc_pkg::CH_COMMA, nmea_rmc_pkg::CH_STAR})
                begin
                    if (in_data_field && (len_reg == '0))
                        err_next = 1'b1;
                    if (idx_reg != nmea_rmc_pkg::FIELD_PAST)
                        idx_next = idx_reg + 3'd1;
                    len_next = '0;
                    if (c == nmea_rmc_pkg::CH_STAR)
                        stopped_next = 1'b1;
                end
                else if (in_data_field)
                begin
                    if (len_reg >= field_limit)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (len_reg == '0)
                        begin
                            case (idx_reg)
                                nmea_rmc_pkg::FIELD_STATUS:
                                    if (c != nmea_rmc_pkg::CH_A)
                                        err_next = 1'b1;
                                nmea_rmc_pkg::FIELD_LAT_HEMI:
                                    if (hemi_hit)
                                        lat_dir_next = hemi_val;
                                    else
                                        err_next = 1'b1;
                                nmea_rmc_pkg::FIELD_LON_HEMI:
                                    if (hemi_hit)
                                        lon_dir_next = hemi_val;
                                    else
                                        err_next = 1'b1;
                                default: ;
                            endcase
                        end
                        if (is_digit && (idx_reg == nmea_rmc_pkg::FIELD_LAT))
                            lat_next = (lat_reg << 3) + (lat_reg << 1) + digit_val;
                        if (is_digit && (idx_reg == nmea_rmc_pkg::FIELD_LON))
                            lon_next = (lon_reg << 3) + (lon_reg << 1) + digit_val;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    // verdict on the sentence as it stands after this byte
    always_comb
    begin
        fix_ok = hdr_ok_next && (phase_next == nmea_rmc_pkg::PH_DONE) && !err_next &&
                 ((idx_next == nmea_rmc_pkg::FIELD_PAST) ||
                  ((idx_next == nmea_rmc_pkg::FIELD_LON_HEMI) && (len_next != '0))) &&
                 (lat_next != 32'd0) && (lon_next != 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sentence.valid && sentence.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sentence.valid && sentence.ready)
            s1_word_reg <= sentence.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= nmea_rmc_pkg::PH_SKIP;
            hdr_pos_reg <= '0;
            hdr_ok_reg  <= 1'b1;
            idx_reg     <= nmea_rmc_pkg::FIELD_FIRST;
            len_reg     <= '0;
            stopped_reg <= 1'b0;
            ended_reg   <= 1'b0;
            err_reg     <= 1'b0;
            lat_reg     <= '0;
            lon_reg     <= '0;
            lat_dir_reg <= nmea_rmc_pkg::HEMI_N;
            lon_dir_reg <= nmea_rmc_pkg::HEMI_N;
        end
        else if (out_load)
        begin
            phase_reg   <= nmea_rmc_pkg::PH_SKIP;
            hdr_pos_reg <= '0;
            hdr_ok_reg  <= 1'b1;
            idx_reg     <= nmea_rmc_pkg::FIELD_FIRST;
            len_reg     <= '0;
            stopped_reg <= 1'b0;
            ended_reg   <= 1'b0;
            err_reg     <= 1'b0;
            lat_reg     <= '0;
            lon_reg     <= '0;
            lat_dir_reg <= nmea_rmc_pkg::HEMI_N;
            lon_dir_reg <= nmea_rmc_pkg::HEMI_N;
        end
        else if (s1_fire)
        begin
            phase_reg   <= phase_next;
            hdr_pos_reg <= hdr_pos_next;
            hdr_ok_reg  <= hdr_ok_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            stopped_reg <= stopped_next;
            ended_reg   <= ended_next;
            err_reg     <= err_next;
            lat_reg     <= lat_next;
            lon_reg     <= lon_next;
            lat_dir_reg <= lat_dir_next;
            lon_dir_reg <= lon_dir_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (fix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg.fix_valid <= fix_ok;
            out_word_reg.lat_raw   <= fix_ok ? lat_next : 32'd0;
            out_word_reg.lat_hemi  <= fix_ok ? lat_dir_next : nmea_rmc_pkg::HEMI_N;
            out_word_reg.lon_raw   <= fix_ok ? lon_next : 32'd0;
            out_word_reg.lon_hemi  <= fix_ok ? lon_dir_next : nmea_rmc_pkg::HEMI_N;
        end
    end

    `NMEA_RMC_ASSERT_NOW(a_no_fix_zero, out_valid_reg && !out_word_reg.fix_valid, (out_word_reg.lat_raw == 32'd0) && (out_word_reg.lon_raw == 32'd0) && (out_word_reg.lat_hemi == 2'd0) && (out_word_reg.lon_hemi == 2'd0), "failed sentence carries nonzero fields")
    `NMEA_RMC_ASSERT_NEXT(a_restart, out_load, (phase_reg == nmea_rmc_pkg::PH_SKIP) && (idx_reg == nmea_rmc_pkg::FIELD_FIRST) && !err_reg && !ended_reg && out_valid_reg, "parser not restarted after final byte")
    `NMEA_RMC_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= COORD_LIM || len_reg <= SHORT_LIM, "field length past its limit")
    `NMEA_RMC_ASSERT_NOW(a_stall_blocks, s1_valid_reg && !s1_fire, !sentence.ready, "byte accepted over a stalled byte")

endmodule
